@@ design/ccm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_pkg
// Opcodes, register indexes, result widths and the saturation helper for the
// covariance / correlation matrix engine.
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam logic [1:0] OP_CENTRAL  = 2'd0;
    localparam logic [1:0] OP_UNIVERSE = 2'd1;
    localparam logic [1:0] OP_REPORT   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] REG_BINS   = 2'd0;
    localparam logic [1:0] REG_UCOUNT = 2'd1;

    localparam int SUM_W      = 60;
    localparam int COV_W      = 48;
    localparam int CORR_W     = 16;
    localparam int FRAC_W     = 32;
    localparam int SQRT_W     = 24;
    localparam int CORR_SHIFT = 14;
    localparam int FRAC_SHIFT = 16;

    // magnitude plus sign to a saturated two's complement value of the given width
    function automatic logic [63:0] sat_mag(input logic [63:0] mag, input logic neg,
                                            input int bits);
        logic [63:0] lim;
        lim = 64'd1 << (bits - 1);
        if (mag >= lim) begin
            sat_mag = neg ? (~lim + 64'd1) : (lim - 64'd1);
        end else begin
            sat_mag = neg ? (~mag + 64'd1) : mag;
        end
    endfunction

endpackage

@@ design/covariance_correlation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// covariance_correlation_matrix
// Accumulates outer products of central-minus-universe deviations and reports
// covariance, correlation and fractional covariance for each matrix entry.
// Load and clear beats are taken in idle. The last universe bin accumulates all n*n
// entries through one multiplier. Report: diagonal roots, then each entry with up to
// three divisions and an output wait; the shared radix-2 divider does every division.
// Sync active-low reset clears control and sum valid bits; sets bins 6, ucount 200.
// ----------------------------------------------------------------------------
module covariance_correlation_matrix #(
    parameter int MAX_BINS    = 8,
    parameter int VALUE_WIDTH = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // bin_index[2:0], bin_value[26:3], zero pad
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // row, column, covariance, correlation,
                                    // fractional_covariance, zero pad
    output logic [1:0]   m_tuser,   // correlation_undefined, fraction_undefined
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data
);
    import ccm_pkg::*;

    localparam int IW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DEP  = MAX_BINS * MAX_BINS;
    localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int MULW = (VALUE_WIDTH > SQRT_W) ? VALUE_WIDTH : SQRT_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_AI    = 5'd1;
    localparam logic [4:0] S_AJ    = 5'd2;
    localparam logic [4:0] S_AADD  = 5'd3;
    localparam logic [4:0] S_DRD   = 5'd4;
    localparam logic [4:0] S_DDIV  = 5'd5;
    localparam logic [4:0] S_DSQ   = 5'd6;
    localparam logic [4:0] S_SQRT  = 5'd7;
    localparam logic [4:0] S_DST   = 5'd8;
    localparam logic [4:0] S_ERD   = 5'd9;
    localparam logic [4:0] S_EDIV  = 5'd10;
    localparam logic [4:0] S_ESI   = 5'd11;
    localparam logic [4:0] S_ESJ   = 5'd12;
    localparam logic [4:0] S_ECJ   = 5'd13;
    localparam logic [4:0] S_ECD   = 5'd14;
    localparam logic [4:0] S_EFR   = 5'd15;
    localparam logic [4:0] S_EOUT  = 5'd16;
    localparam logic [4:0] S_WAIT  = 5'd17;
    localparam logic [4:0] S_DIV   = 5'd18;

    logic [4:0]             state_reg;
    logic [4:0]             div_ret_reg;
    logic [3:0]             bins_reg;
    logic [9:0]             ucount_reg;
    logic [3:0]             n_reg;
    logic [9:0]             uc_reg;
    logic [IW-1:0]          i_reg, j_reg;

    logic [VALUE_WIDTH-1:0] cv_mem [MAX_BINS];
    logic [VALUE_WIDTH-1:0] uv_mem [MAX_BINS];
    logic [SQRT_W-1:0]      sd_mem [MAX_BINS];
    logic [SUM_W-1:0]       sum_mem [DEP];
    logic [DEP-1:0]         sum_vld_reg;
    logic [SUM_W-1:0]       sum_rd_reg;

    logic [VALUE_WIDTH-1:0] dva_reg;
    logic                   nga_reg, pn_reg;
    logic [SQRT_W-1:0]      sda_reg;
    logic [VALUE_WIDTH-1:0] cva_reg;
    logic [2*MULW-1:0]      mul_reg;
    logic [63:0]            den_reg, pcv_reg;
    logic [COV_W-1:0]       cm_reg;
    logic                   neg_reg;

    logic [63:0]            div_num_reg, div_dvs_reg, div_quo_reg;
    logic [64:0]            div_rem_reg;
    logic [6:0]             div_cnt_reg;

    logic [47:0]            sq_v_reg;
    logic [26:0]            sq_rem_reg;
    logic [SQRT_W-1:0]      sq_root_reg;
    logic [4:0]             sq_cnt_reg;

    logic                   m_tvalid_reg, m_tlast_reg;
    logic [2:0]             row_reg, col_reg;
    logic [COV_W-1:0]       cov_reg;
    logic [CORR_W-1:0]      corr_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic                   cund_reg, fund_reg;

    logic [1:0]             in_op;
    logic [2:0]             in_idx;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   in_ok;
    logic [3:0]             n_now;
    logic [IW-1:0]          rd_idx;
    logic [VALUE_WIDTH-1:0] cv_rd, uv_rd, dev_mag;
    logic                   dev_neg;
    logic [SQRT_W-1:0]      sd_rd;
    logic [MULW-1:0]        mul_a, mul_b;
    logic [AW-1:0]          sum_addr;
    logic                   sum_ren;
    logic                   i_last, j_last;
    logic [61:0]            acc_t;
    logic [SUM_W-1:0]       acc_sat;
    logic                   acc_big;
    logic [64:0]            div_sh, div_sub;
    logic                   div_ge;
    logic [26:0]            sq_sh, sq_trial;
    logic                   sq_ge;
    logic [COV_W-1:0]       cov_q;

    assign in_op  = s_tuser;
    assign in_idx = s_tdata[2:0];
    assign in_val = VALUE_WIDTH'(s_tdata[26:3]);
    assign in_ok  = 32'(in_idx) < MAX_BINS;
    assign n_now  = (bins_reg == 4'd0) ? 4'd1 :
                    (32'(bins_reg) > MAX_BINS) ? 4'(MAX_BINS) : bins_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = {fund_reg, cund_reg};
    assign m_tdata   = {2'b00, frac_reg, corr_reg, cov_reg, col_reg, row_reg};

    assign i_last = (4'(i_reg) == n_reg - 4'd1);
    assign j_last = (4'(j_reg) == n_reg - 4'd1);

    assign rd_idx  = (state_reg == S_AJ || state_reg == S_ESJ || state_reg == S_ECJ) ?
                     j_reg : i_reg;
    assign cv_rd   = cv_mem[rd_idx];
    assign uv_rd   = uv_mem[rd_idx];
    assign sd_rd   = sd_mem[rd_idx];
    assign dev_neg = uv_rd > cv_rd;
    assign dev_mag = dev_neg ? (uv_rd - cv_rd) : (cv_rd - uv_rd);

    always_comb begin
        case (state_reg)
            S_AJ: begin
                mul_a = MULW'(dva_reg);
                mul_b = MULW'(dev_mag);
            end
            S_ESJ: begin
                mul_a = MULW'(sda_reg);
                mul_b = MULW'(sd_rd);
            end
            default: begin
                mul_a = MULW'(cva_reg);
                mul_b = MULW'(cv_rd);
            end
        endcase
    end

    always_comb begin
        sum_ren  = (state_reg == S_AI) || (state_reg == S_DRD) || (state_reg == S_ERD);
        sum_addr = (state_reg == S_DRD) ? AW'(32'(i_reg) * MAX_BINS + 32'(i_reg)) :
                                          AW'(32'(i_reg) * MAX_BINS + 32'(j_reg));
    end

    // saturating accumulate of one outer-product term
    always_comb begin
        acc_big = 64'(mul_reg) > (64'd1 << SUM_W);
        acc_t   = pn_reg ?
                  ({{2{sum_rd_reg[SUM_W-1]}}, sum_rd_reg} - 62'(64'(mul_reg))) :
                  ({{2{sum_rd_reg[SUM_W-1]}}, sum_rd_reg} + 62'(64'(mul_reg)));
        if (acc_big || (acc_t[61:59] != 3'b000 && acc_t[61:59] != 3'b111)) begin
            acc_sat = (acc_big ? pn_reg : acc_t[61]) ?
                      {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            acc_sat = acc_t[SUM_W-1:0];
        end
    end

    assign div_sh  = {div_rem_reg[63:0], div_num_reg[63]};
    assign div_ge  = div_sh >= {1'b0, div_dvs_reg};
    assign div_sub = div_sh - {1'b0, div_dvs_reg};

    assign sq_sh    = {sq_rem_reg[24:0], sq_v_reg[47:46]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign cov_q = COV_W'(sat_mag(div_quo_reg, neg_reg, COV_W));

    always_ff @(posedge aclk) begin
        if (sum_ren) begin
            sum_rd_reg <= sum_vld_reg[sum_addr] ? sum_mem[sum_addr] : '0;
        end
        if (state_reg == S_AADD) begin
            sum_mem[sum_addr] <= acc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_ret_reg  <= S_IDLE;
            bins_reg     <= 4'd6;
            ucount_reg   <= 10'd200;
            sum_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            div_cnt_reg  <= '0;
            sq_cnt_reg   <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= 4'd1;
            uc_reg       <= 10'd1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BINS:   bins_reg   <= cfg_data[3:0];
                    REG_UCOUNT: ucount_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        n_reg  <= n_now;
                        uc_reg <= (ucount_reg == 10'd0) ? 10'd1 : ucount_reg;
                        i_reg  <= '0;
                        j_reg  <= '0;
                        case (in_op)
                            OP_CENTRAL: begin
                                if (in_ok) cv_mem[in_idx[IW-1:0]] <= in_val;
                            end
                            OP_UNIVERSE: begin
                                if (in_ok) begin
                                    uv_mem[in_idx[IW-1:0]] <= in_val;
                                    if ({1'b0, in_idx} == n_now - 4'd1) state_reg <= S_AI;
                                end
                            end
                            OP_REPORT: state_reg <= S_DRD;
                            default:   sum_vld_reg <= '0;
                        endcase
                    end
                end
                S_AI: begin
                    dva_reg   <= dev_mag;
                    nga_reg   <= dev_neg;
                    state_reg <= S_AJ;
                end
                S_AJ: begin
                    mul_reg   <= mul_a * mul_b;
                    pn_reg    <= nga_reg != dev_neg;
                    state_reg <= S_AADD;
                end
                S_AADD: begin
                    sum_vld_reg[sum_addr] <= 1'b1;
                    state_reg <= S_AI;
                    if (j_last) begin
                        j_reg <= '0;
                        if (i_last) state_reg <= S_IDLE;
                        else        i_reg <= i_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRD: state_reg <= S_DDIV;
                S_DDIV, S_EDIV: begin
                    neg_reg     <= sum_rd_reg[SUM_W-1];
                    div_num_reg <= 64'(sum_rd_reg[SUM_W-1] ? SUM_W'(~sum_rd_reg + 1'b1)
                                                           : sum_rd_reg);
                    div_dvs_reg <= 64'(uc_reg);
                    div_rem_reg <= '0;
                    div_cnt_reg <= 7'd64;
                    div_ret_reg <= (state_reg == S_DDIV) ? S_DSQ : S_ESI;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    div_rem_reg <= div_ge ? div_sub : div_sh;
                    div_quo_reg <= {div_quo_reg[62:0], div_ge};
                    div_num_reg <= {div_num_reg[62:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 7'd1) state_reg <= div_ret_reg;
                end
                S_DSQ: begin
                    if (!cov_q[COV_W-1] && cov_q != '0) begin
                        sq_v_reg    <= cov_q;
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        sq_cnt_reg  <= 5'(SQRT_W);
                        state_reg   <= S_SQRT;
                    end else begin
                        sd_mem[i_reg] <= '0;
                        state_reg     <= S_DST;
                    end
                end
                S_SQRT: begin
                    sq_rem_reg  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                    sq_root_reg <= {sq_root_reg[SQRT_W-2:0], sq_ge};
                    sq_v_reg    <= {sq_v_reg[45:0], 2'b00};
                    sq_cnt_reg  <= sq_cnt_reg - 1'b1;
                    if (sq_cnt_reg == 5'd1) begin
                        sd_mem[i_reg] <= {sq_root_reg[SQRT_W-2:0], sq_ge};
                        state_reg     <= S_DST;
                    end
                end
                S_DST: begin
                    if (i_last) begin
                        i_reg     <= '0;
                        state_reg <= S_ERD;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DRD;
                    end
                end
                S_ERD: state_reg <= S_EDIV;
                S_ESI: begin
                    cov_reg   <= cov_q;
                    cm_reg    <= cov_q[COV_W-1] ? (~cov_q + 1'b1) : cov_q;
                    sda_reg   <= sd_rd;
                    cva_reg   <= cv_rd;
                    state_reg <= S_ESJ;
                end
                S_ESJ: begin
                    mul_reg   <= mul_a * mul_b;
                    state_reg <= S_ECJ;
                end
                S_ECJ: begin
                    den_reg   <= 64'(mul_reg);
                    mul_reg   <= mul_a * mul_b;
                    state_reg <= S_ECD;
                end
                S_ECD: begin
                    pcv_reg  <= 64'(mul_reg);
                    cund_reg <= den_reg == 64'd0;
                    if (den_reg != 64'd0) begin
                        div_num_reg <= 64'(cm_reg) << CORR_SHIFT;
                        div_dvs_reg <= den_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= 7'd64;
                        div_ret_reg <= S_EFR;
                        state_reg   <= S_DIV;
                    end else begin
                        state_reg <= S_EFR;
                    end
                end
                S_EFR: begin
                    corr_reg <= cund_reg ? '0 :
                                CORR_W'(sat_mag(div_quo_reg, cov_reg[COV_W-1], CORR_W));
                    fund_reg <= pcv_reg == 64'd0;
                    if (pcv_reg != 64'd0) begin
                        div_num_reg <= 64'(cm_reg) << FRAC_SHIFT;
                        div_dvs_reg <= pcv_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= 7'd64;
                        div_ret_reg <= S_EOUT;
                        state_reg   <= S_DIV;
                    end else begin
                        state_reg <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    frac_reg     <= fund_reg ? '0 :
                                    FRAC_W'(sat_mag(div_quo_reg, cov_reg[COV_W-1], FRAC_W));
                    row_reg      <= 3'(i_reg);
                    col_reg      <= 3'(j_reg);
                    m_tlast_reg  <= i_last && j_last;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_ERD;
                        if (j_last) begin
                            j_reg <= '0;
                            if (i_last) state_reg <= S_IDLE;
                            else        i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("result beat while accepting input");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("report run did not end after last beat");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg != 7'd0))
        else $error("divider running with zero count");

    a_sqrt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> (sq_cnt_reg != 5'd0))
        else $error("root unit running with zero count");

endmodule

@@ tb/sv/covariance_correlation_matrix_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// covariance_correlation_matrix_tb
// Self-checking bench for the covariance / correlation matrix engine. A short
// directed table loads the extreme bin values, reports an empty and a filled
// matrix and clears it. Random phases then sweep the two registers and stream
// universes with random content, noise loads, clears and reports. Each output
// beat is checked field by field against a predictor built in this file. Both
// sides idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module covariance_correlation_matrix_tb;
    import ccm_pkg::*;

    localparam int WDOG_LIMIT = 40000;
    localparam int SETTLE     = 300;
    localparam int HOLD_LEN   = 3000;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [47:0] cov;
        logic [15:0] corr;
        logic [31:0] frac;
        logic        corr_undef;
        logic        frac_undef;
        logic        last;
        logic        zero_chk;
    } entry_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  code;
        logic [2:0]  idx;
        logic [23:0] val;
        logic        zero_chk;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [9:0]   cfg_data;

    covariance_correlation_matrix DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [23:0] mdl_central [8];
    logic [23:0] mdl_universe [8];
    longint      mdl_sums [64];
    logic [3:0]  mdl_bins;
    logic [9:0]  mdl_ucount;

    entry_t matrix_q [$];
    int     errors;
    int     items_in;
    int     entries_out;
    int     reports_sent;
    bit     in_fire, out_fire, cfg_fire;
    bit     no_idle;
    bit     long_hold;

    dir_row_t dir_tab [22] = '{
        '{1'b1, REG_BINS,    3'd0, 24'd8,        1'b0},
        '{1'b0, OP_CENTRAL,  3'd0, 24'd0,        1'b0},
        '{1'b0, OP_CENTRAL,  3'd1, 24'hFFFFFF,   1'b0},
        '{1'b0, OP_CENTRAL,  3'd2, 24'd1,        1'b0},
        '{1'b0, OP_CENTRAL,  3'd3, 24'h010000,   1'b0},
        '{1'b0, OP_CENTRAL,  3'd4, 24'h800000,   1'b0},
        '{1'b0, OP_CENTRAL,  3'd5, 24'h7FFFFF,   1'b0},
        '{1'b0, OP_CENTRAL,  3'd6, 24'h123456,   1'b0},
        '{1'b0, OP_CENTRAL,  3'd7, 24'h00FFFF,   1'b0},
        '{1'b0, OP_REPORT,   3'd0, 24'd0,        1'b1},
        '{1'b0, OP_UNIVERSE, 3'd0, 24'hFFFFFF,   1'b0},
        '{1'b0, OP_UNIVERSE, 3'd1, 24'd0,        1'b0},
        '{1'b0, OP_UNIVERSE, 3'd2, 24'd1,        1'b0},
        '{1'b0, OP_UNIVERSE, 3'd3, 24'h00FFFF,   1'b0},
        '{1'b0, OP_UNIVERSE, 3'd4, 24'h000000,   1'b0},
        '{1'b0, OP_UNIVERSE, 3'd5, 24'hFFFFFF,   1'b0},
        '{1'b0, OP_UNIVERSE, 3'd6, 24'h654321,   1'b0},
        '{1'b0, OP_UNIVERSE, 3'd7, 24'hFF0000,   1'b0},
        '{1'b0, OP_REPORT,   3'd0, 24'd0,        1'b0},
        '{1'b0, OP_CLEAR,    3'd0, 24'd0,        1'b0},
        '{1'b0, OP_REPORT,   3'd0, 24'd0,        1'b1},
        '{1'b1, REG_UCOUNT,  3'd0, 24'd1,        1'b0}
    };

    function automatic longint clip_mag(logic [63:0] mag, bit neg, int bits);
        logic [63:0] lim;
        lim = 64'd1 << (bits - 1);
        if (neg) begin
            clip_mag = (mag >= lim) ? -longint'(lim) : -longint'(mag);
        end else begin
            clip_mag = (mag >= lim) ? longint'(lim - 64'd1) : longint'(mag);
        end
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic int used_bins();
        if (mdl_bins == 4'd0) return 1;
        if (mdl_bins > 4'd8) return 8;
        return int'(mdl_bins);
    endfunction

    task automatic add_outer_product(int n);
        logic [63:0] mag [8];
        bit          neg [8];
        logic [63:0] p;
        bit          pn;
        longint      t;
        longint      hi;
        hi = (longint'(1) <<< 59) - 1;
        for (int i = 0; i < n; i++) begin
            neg[i] = mdl_universe[i] > mdl_central[i];
            mag[i] = neg[i] ? 64'(mdl_universe[i] - mdl_central[i])
                            : 64'(mdl_central[i] - mdl_universe[i]);
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                p  = mag[i] * mag[j];
                pn = (neg[i] != neg[j]) && (p != 64'd0);
                t  = pn ? mdl_sums[i*8+j] - longint'(p) : mdl_sums[i*8+j] + longint'(p);
                if (t > hi) t = hi;
                if (t < -hi - 1) t = -hi - 1;
                mdl_sums[i*8+j] = t;
            end
        end
    endtask

    task automatic predict_matrix(bit zchk);
        int          n;
        logic [63:0] uc;
        longint      cov [64];
        longint      s;
        longint      c;
        logic [63:0] si, sj, den, pcv, cm;
        bit          cn;
        entry_t      e;
        n  = used_bins();
        uc = (mdl_ucount == 10'd0) ? 64'd1 : 64'(mdl_ucount);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                s = mdl_sums[i*8+j];
                cov[i*8+j] = clip_mag(64'(s < 0 ? -s : s) / uc, s < 0, COV_W);
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                c   = cov[i*8+j];
                si  = cov[i*8+i] > 0 ? root_floor(64'(cov[i*8+i])) : 64'd0;
                sj  = cov[j*8+j] > 0 ? root_floor(64'(cov[j*8+j])) : 64'd0;
                den = si * sj;
                pcv = 64'(mdl_central[i]) * 64'(mdl_central[j]);
                cn  = c < 0;
                cm  = cn ? 64'(-c) : 64'(c);
                e.row  = 3'(i);
                e.col  = 3'(j);
                e.cov  = 48'(c);
                e.corr = (den != 0) ? 16'(clip_mag((cm << CORR_SHIFT) / den, cn, CORR_W)) : '0;
                e.frac = (pcv != 0) ? 32'(clip_mag((cm << FRAC_SHIFT) / pcv, cn, FRAC_W)) : '0;
                e.corr_undef = (den == 0);
                e.frac_undef = (pcv == 0);
                e.last       = (i == n - 1) && (j == n - 1);
                e.zero_chk   = zchk;
                matrix_q.push_back(e);
            end
        end
    endtask

    task automatic predict_item(logic [1:0] op, logic [2:0] idx, logic [23:0] val, bit zchk);
        case (op)
            OP_CENTRAL: begin
                mdl_central[idx] = val;
            end
            OP_UNIVERSE: begin
                mdl_universe[idx] = val;
                if (int'(idx) == used_bins() - 1) add_outer_product(used_bins());
            end
            OP_CLEAR: begin
                for (int k = 0; k < 64; k++) mdl_sums[k] = 0;
            end
            default: begin
                predict_matrix(zchk);
            end
        endcase
    endtask

    // zero-check marker for the beat currently being driven
    bit cur_zchk;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        entry_t e;
        in_fire  <= s_tvalid && s_tready;
        out_fire <= m_tvalid && m_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (aresetn && m_tvalid && m_tready) begin
            entries_out++;
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected output beat row %0d col %0d", $time,
                         m_tdata[2:0], m_tdata[5:3]);
                errors++;
            end else begin
                e = matrix_q.pop_front();
                if (m_tdata[2:0] !== e.row || m_tdata[5:3] !== e.col ||
                    m_tdata[53:6] !== e.cov || m_tdata[69:54] !== e.corr ||
                    m_tdata[101:70] !== e.frac || m_tuser[0] !== e.corr_undef ||
                    m_tuser[1] !== e.frac_undef || m_tlast !== e.last) begin
                    $display("%0t: mismatch exp row %0d col %0d cov %h corr %h frac %h cu %b fu %b last %b",
                             $time, e.row, e.col, e.cov, e.corr, e.frac,
                             e.corr_undef, e.frac_undef, e.last);
                    $display("%0t:          got row %0d col %0d cov %h corr %h frac %h cu %b fu %b last %b",
                             $time, m_tdata[2:0], m_tdata[5:3], m_tdata[53:6], m_tdata[69:54],
                             m_tdata[101:70], m_tuser[0], m_tuser[1], m_tlast);
                    errors++;
                end
                if (e.zero_chk && (m_tdata[53:6] !== '0 || m_tuser[0] !== 1'b1)) begin
                    $display("%0t: cleared matrix exp cov 0 cu 1, got cov %h cu %b",
                             $time, m_tdata[53:6], m_tuser[0]);
                    errors++;
                end
            end
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_BINS) mdl_bins = cfg_data[3:0];
            else if (cfg_index == REG_UCOUNT) mdl_ucount = cfg_data;
        end
        if (aresetn && s_tvalid && s_tready) begin
            items_in++;
            predict_item(s_tuser, s_tdata[2:0], s_tdata[26:3], cur_zchk);
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d entries pending", $time, matrix_q.size());
                $display("[covariance_correlation_matrix] ERROR");
                $finish;
            end
        end
    end

    // result receiver
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                long_hold = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!out_fire && !long_hold);
        end
    end

    task automatic send_item(logic [1:0] op, logic [2:0] idx, logic [23:0] val, bit zchk);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, val, idx};
        cur_zchk <= zchk;
        if (op == OP_REPORT) reports_sent++;
        do @(negedge aclk); while (!in_fire);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (matrix_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [9:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_value(logic [23:0] cv);
        case ($urandom_range(0, 5))
            0: return cv;
            1: return 24'hFFFFFF;
            2: return 24'd0;
            3: return cv + 24'($urandom_range(0, 4095)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int bins_tab [8]  = '{1, 8, 3, 0, 15, 9, 2, 5};
        int ucnt_tab [8]  = '{1, 1023, 0, 7, 200, 512, 3, 64};
        int n;
        int sent;
        errors = 0; items_in = 0; entries_out = 0; reports_sent = 0;
        no_idle = 1'b0; long_hold = 1'b0; cur_zchk = 1'b0;
        in_fire = 1'b0; out_fire = 1'b0; cfg_fire = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_CENTRAL;
        cfg_valid = 1'b0; cfg_index = REG_BINS; cfg_data = '0;
        for (int k = 0; k < 8; k++) begin
            mdl_central[k] = '0;
            mdl_universe[k] = '0;
        end
        for (int k = 0; k < 64; k++) mdl_sums[k] = 0;
        mdl_bins = 4'd6;
        mdl_ucount = 10'd200;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg)
                write_reg(dir_tab[r].code, dir_tab[r].val[9:0]);
            else
                send_item(dir_tab[r].code, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].zero_chk);
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BINS, 10'(bins_tab[ph]));
            write_reg(REG_UCOUNT, 10'(ucnt_tab[ph]));
            no_idle = (ph % 3 == 1);
            n = (bins_tab[ph] == 0) ? 1 : (bins_tab[ph] > 8 ? 8 : bins_tab[ph]);
            sent = 0;
            while (sent < 30) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_item($urandom_range(0, 1) ? OP_UNIVERSE : OP_CENTRAL,
                                  3'($urandom_range(0, 7)), 24'($urandom), 1'b0);
                        sent++;
                    end
                    1: begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_item(OP_CLEAR, 3'($urandom), 24'($urandom), 1'b0);
                            sent++;
                        end
                    end
                    2: begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_item(OP_REPORT, 3'($urandom), 24'($urandom), 1'b0);
                            sent++;
                        end
                    end
                    default: begin
                        for (int b = 0; b < n; b++)
                            send_item(OP_UNIVERSE, 3'(b), rand_value(mdl_central[b]), 1'b0);
                        sent += n;
                    end
                endcase
            end
            if (ph == 2) long_hold = 1'b1;
            send_item(OP_REPORT, 3'($urandom), 24'($urandom), 1'b0);
            if (ph == 2) begin
                for (int b = 0; b < 6; b++)
                    send_item(OP_CENTRAL, 3'(b), 24'($urandom), 1'b0);
            end
        end

        drain();
        $display("Run covered %0d input beats and %0d reports, %0d matrix entries checked,",
                 items_in, reports_sent, entries_out);
        $display("over eight register settings including zero, one and max bins and counts.");
        if (errors == 0 && matrix_q.size() == 0) begin
            $display("[covariance_correlation_matrix] OK");
        end else begin
            $display("[covariance_correlation_matrix] ERROR");
        end
        $finish;
    end

endmodule

@@ covariance_correlation_matrix.f @@
design/ccm_pkg.sv
design/covariance_correlation_matrix.sv
tb/sv/covariance_correlation_matrix_tb.sv
